FILE: rtl/port_bitmap_allocator_top_assert.svh
// assertion macros for the port bitmap allocator checker
`ifndef PORT_BITMAP_ALLOCATOR_TOP_ASSERT_SVH
`define PORT_BITMAP_ALLOCATOR_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define PBA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("port bitmap allocator check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define PBA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("port bitmap allocator check failed");

`endif

FILE: rtl/pba_pkg.sv
// shared types and constants of the port bitmap allocator
`default_nettype none

package pba_pkg;

  // table geometry
  localparam int NUM_PORTS = 1024;
  localparam int PORT_W    = 10;
  localparam int WORD_W    = 64;
  localparam int BIT_W     = $clog2(WORD_W);
  localparam int NUM_ROWS  = NUM_PORTS / WORD_W;
  localparam int ROW_W     = $clog2(NUM_ROWS);
  localparam int CFG_IDX_W = 2;

  // request kinds
  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_RESERVE = 2'd2,
    OP_QUERY   = 2'd3
  } op_t;

  // result status codes
  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_RANGE     = 2'd1,
    STAT_OCCUPIED  = 2'd2,
    STAT_NONE_FREE = 2'd3
  } status_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DYN_LOW  = 2'd0,
    CFG_DYN_HIGH = 2'd1
  } cfg_idx_t;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_PORT,
    S_SCAN,
    S_DONE
  } pba_state_t;

endpackage

`default_nettype wire

FILE: rtl/port_bitmap_allocator_top.sv
// port bitmap allocator: used/free table in a word-wide memory with a scan sequencer
//
// Input channel (in_valid/in_stall, in_op, in_port_num) takes one request at a time;
// in_stall is high while a request is being worked on. Result channel (out_valid/
// out_stall, out_port_out, out_status, out_is_used) gives one result per request from
// an output register, so a new request is taken while the last result still waits.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes dyn_low (index 0)
// and dyn_high (index 1); cfg_ready is always high, other indexes are dropped.
// The table is 16 words of 64 marks in a memory with a registered read.
// Free, reserve and query pass through S_PORT (modify and write back), then S_DONE,
// which loads the output register. Allocate scans from the word holding dyn_low to
// the one holding the granted port or dyn_high, one word per cycle, then loads the
// output register from S_DONE. An empty range (dyn_low above dyn_high) goes straight
// to S_DONE with no scan. The next request can be accepted in the cycle the previous
// result appears.
// Reset clears 16 per-word valid flags, so the whole table reads free at once with
// no clearing pass, and sets dyn_low to 512 and dyn_high to 1023.
// A stalled receiver holds the result register; a further finished result then
// waits in the sequencer, which stops taking requests until the register drains.
`default_nettype none

module port_bitmap_allocator_top
  import pba_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // request channel
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [1:0]           in_op,
  input  wire logic [PORT_W-1:0]    in_port_num,
  // result channel
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [PORT_W-1:0]         out_port_out,
  output logic [1:0]                out_status,
  output logic                      out_is_used,
  // configuration channel
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [PORT_W-1:0]    cfg_data
);

  localparam logic [PORT_W:0]  NUM_PORTS_C = (PORT_W+1)'(NUM_PORTS);
  localparam logic [BIT_W-1:0] TOP_BIT     = BIT_W'(WORD_W-1);

  // control state
  pba_state_t           state_r, state_nxt;
  logic [NUM_ROWS-1:0]  row_valid_r, row_valid_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [PORT_W-1:0]    dyn_low_r, dyn_high_r;

  // working registers
  op_t                  op_r, op_nxt;
  logic [PORT_W-1:0]    port_r, port_nxt;
  logic [ROW_W-1:0]     row_r, row_nxt;
  logic [PORT_W-1:0]    res_port_r, res_port_nxt;
  status_t              res_status_r, res_status_nxt;
  logic                 res_used_r, res_used_nxt;
  logic [PORT_W-1:0]    out_port_r;
  status_t              out_status_r;
  logic                 out_used_r;

  // memory
  logic [WORD_W-1:0]    map_mem [NUM_ROWS];
  logic [WORD_W-1:0]    mem_rdata_r;
  logic                 rd_valid_r;
  logic                 mem_we;
  logic [ROW_W-1:0]     mem_waddr, mem_raddr;
  logic [WORD_W-1:0]    mem_wdata;

  // datapath
  logic [WORD_W-1:0]    rd_word;
  logic [ROW_W-1:0]     lo_row, hi_row;
  logic [WORD_W-1:0]    lo_mask, hi_mask, zero_mask, cand;
  logic                 found;
  logic [BIT_W-1:0]     found_idx;
  logic [WORD_W-1:0]    port_oh, found_oh;
  logic                 bit_used, port_bad, out_load;
  op_t                  in_op_t;

  assign in_op_t = op_t'(in_op);
  assign lo_row  = dyn_low_r[PORT_W-1:BIT_W];
  assign hi_row  = dyn_high_r[PORT_W-1:BIT_W];

  // a word never written since reset reads as all free
  assign rd_word = rd_valid_r ? mem_rdata_r : '0;

  // candidate marks of the word under scan, limited to the dynamic range, port 0 excluded
  always_comb begin
    lo_mask   = (row_r == lo_row) ? ({WORD_W{1'b1}} << dyn_low_r[BIT_W-1:0])
                                  : {WORD_W{1'b1}};
    hi_mask   = (row_r == hi_row) ? ({WORD_W{1'b1}} >> (TOP_BIT - dyn_high_r[BIT_W-1:0]))
                                  : {WORD_W{1'b1}};
    zero_mask = (row_r == '0) ? ~WORD_W'(1) : {WORD_W{1'b1}};
    cand      = ~rd_word & lo_mask & hi_mask & zero_mask;
  end

  // lowest free candidate
  always_comb begin
    found     = 1'b0;
    found_idx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (cand[i]) begin
        found     = 1'b1;
        found_idx = BIT_W'(i);
      end
    end
  end

  assign found_oh = WORD_W'(1) << found_idx;
  assign port_oh  = WORD_W'(1) << port_r[BIT_W-1:0];
  assign bit_used = rd_word[port_r[BIT_W-1:0]];
  assign port_bad = ({1'b0, port_r} >= NUM_PORTS_C) ||
                    ((port_r == '0) && (op_r != OP_QUERY));

  assign out_load = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  // sequencer: next state, memory access and result
  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    port_nxt       = port_r;
    row_nxt        = row_r;
    res_port_nxt   = res_port_r;
    res_status_nxt = res_status_r;
    res_used_nxt   = res_used_r;
    row_valid_nxt  = row_valid_r;
    mem_we         = 1'b0;
    mem_waddr      = row_r;
    mem_wdata      = rd_word;
    mem_raddr      = row_r;
    in_stall       = (state_r != S_IDLE);

    case (state_r)
      S_IDLE: begin
        mem_raddr = (in_op_t == OP_ALLOC) ? lo_row : in_port_num[PORT_W-1:BIT_W];
        if (in_valid) begin
          op_nxt   = in_op_t;
          port_nxt = in_port_num;
          row_nxt  = mem_raddr;
          if (in_op_t == OP_ALLOC) begin
            if (dyn_low_r > dyn_high_r) begin
              res_port_nxt   = '0;
              res_status_nxt = STAT_NONE_FREE;
              res_used_nxt   = 1'b0;
              state_nxt      = S_DONE;
            end else begin
              state_nxt = S_SCAN;
            end
          end else begin
            state_nxt = S_PORT;
          end
        end
      end

      S_PORT: begin
        res_port_nxt = '0;
        res_used_nxt = port_bad ? 1'b0 : bit_used;
        if (port_bad) begin
          res_status_nxt = STAT_RANGE;
        end else if ((op_r == OP_RESERVE) && bit_used) begin
          res_status_nxt = STAT_OCCUPIED;
        end else begin
          res_status_nxt = STAT_OK;
        end
        if (!port_bad && (op_r == OP_FREE)) begin
          mem_we    = 1'b1;
          mem_wdata = rd_word & ~port_oh;
        end else if (!port_bad && (op_r == OP_RESERVE) && !bit_used) begin
          mem_we    = 1'b1;
          mem_wdata = rd_word | port_oh;
        end
        if (mem_we) begin
          row_valid_nxt[row_r] = 1'b1;
        end
        state_nxt = S_DONE;
      end

      S_SCAN: begin
        // fetch the following word in case this one has no free mark
        mem_raddr    = row_r + ROW_W'(1);
        res_used_nxt = 1'b0;
        if (found) begin
          mem_we               = 1'b1;
          mem_wdata            = rd_word | found_oh;
          row_valid_nxt[row_r] = 1'b1;
          res_port_nxt         = {row_r, found_idx};
          res_status_nxt       = STAT_OK;
          state_nxt            = S_DONE;
        end else if (row_r == hi_row) begin
          res_port_nxt   = '0;
          res_status_nxt = STAT_NONE_FREE;
          state_nxt      = S_DONE;
        end else begin
          row_nxt = mem_raddr;
        end
      end

      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // result register handshake
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      row_valid_r <= '0;
      out_valid_r <= 1'b0;
      dyn_low_r   <= PORT_W'(512);
      dyn_high_r  <= PORT_W'(1023);
    end else begin
      state_r     <= state_nxt;
      row_valid_r <= row_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_DYN_LOW:  dyn_low_r  <= cfg_data;
          CFG_DYN_HIGH: dyn_high_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    port_r       <= port_nxt;
    row_r        <= row_nxt;
    res_port_r   <= res_port_nxt;
    res_status_r <= res_status_nxt;
    res_used_r   <= res_used_nxt;
    rd_valid_r   <= row_valid_r[mem_raddr];
    if (out_load) begin
      out_port_r   <= res_port_r;
      out_status_r <= res_status_r;
      out_used_r   <= res_used_r;
    end
  end

  // bitmap memory, at most one word written and one read each cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      map_mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_r <= map_mem[mem_raddr];
  end

  assign cfg_ready    = 1'b1;
  assign out_valid    = out_valid_r;
  assign out_port_out = out_port_r;
  assign out_status   = out_status_r;
  assign out_is_used  = out_used_r;

endmodule

`default_nettype wire

FILE: rtl/pba_chk.sv
// port-level checker for the port bitmap allocator and its bind
`default_nettype none

`include "port_bitmap_allocator_top_assert.svh"

module pba_chk
  import pba_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic [PORT_W-1:0] out_port_out,
  input wire logic [1:0]        out_status,
  input wire logic              out_is_used
);

  // a stalled result stays put
  `PBA_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_port_out) && $stable(out_status) && $stable(out_is_used))

  // a granted port comes only with success and no prior mark
  `PBA_ASSERT_IMP(a_grant_ok, out_valid && (out_port_out != '0), (out_status == STAT_OK) && !out_is_used)

  // failed requests never carry a port
  `PBA_ASSERT_IMP(a_fail_no_port, out_valid && (out_status != STAT_OK), out_port_out == '0)

  // occupied means the mark was set, out of range or none free means it reads clear
  `PBA_ASSERT_IMP(a_occupied_used, out_valid && (out_status == STAT_OCCUPIED), out_is_used)
  `PBA_ASSERT_IMP(a_range_clear, out_valid && ((out_status == STAT_RANGE) || (out_status == STAT_NONE_FREE)), !out_is_used)

endmodule

bind port_bitmap_allocator_top pba_chk u_pba_chk (.*);

`default_nettype wire
